// ===== rtl/core/glzw_pkg.sv =====
package glzw_pkg;

    localparam int ROOT_BITS    = 8;
    localparam int ROOT_COUNT   = 256;
    localparam int CODE_CLEAR   = 256;
    localparam int CODE_END     = 257;
    localparam int FIRST_FREE   = 257;
    localparam int INIT_WIDTH   = 9;
    localparam int SIZE_BYTE    = 8;
    localparam int BUF_W        = 20;
    localparam int BCNT_W       = 5;
    localparam int CW_W         = 4;
    localparam int FIELD_W      = 12;
    localparam int PIX_PER_GRP  = 64;
    localparam int GRP_W        = PIX_PER_GRP * ROOT_BITS;
    localparam int PCOUNT_W     = 7;
    localparam int TDATA_W      = 520;

    localparam logic [1:0] ST_PIXELS   = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_BAD_SIZE = 2'd3;

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_LEN,
        PH_DATA,
        PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOK,
        BK_LEN,
        BK_WALK,
        BK_FIN,
        BK_FILL,
        BK_EMIT,
        BK_STAT
    } back_state_t;

    // One command per input byte at most: either a status or a string to expand
    typedef struct packed {
        logic               is_status;
        logic [1:0]         status;
        logic [FIELD_W-1:0] walk_code;
        logic               kwk;
        logic               add;
        logic [FIELD_W-1:0] add_addr;
        logic [FIELD_W-1:0] add_prefix;
    } cmd_t;

endpackage

// ===== rtl/core/glzw_front.sv =====
module glzw_front #(
    parameter int DICT_DEPTH    = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  logic              clk,
    input  logic              rstn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_start,
    input  logic              q_full,
    output logic              cmd_push,
    output glzw_pkg::cmd_t    cmd
);

    localparam int AW    = $clog2(DICT_DEPTH);
    localparam int NFC_W = AW + 1;
    localparam int CMP_W = 14;

    glzw_pkg::phase_t phase_reg, phase_next, cur_phase;
    logic [7:0]                   rem_reg, rem_next;
    logic                         stop_reg, stop_next;
    logic [glzw_pkg::BUF_W-1:0]   buf_reg, buf_next;
    logic [glzw_pkg::BCNT_W-1:0]  cnt_reg, cnt_next;
    logic [glzw_pkg::CW_W-1:0]    cw_reg, cw_next;
    logic [NFC_W-1:0]             nfc_reg, nfc_next;
    logic [MAX_CODE_BITS-1:0]     prev_reg, prev_next;
    logic                         fresh_reg, fresh_next;

    logic                         accept;
    logic [glzw_pkg::BUF_W-1:0]   merged, code_mask, code_full;
    logic [glzw_pkg::BCNT_W-1:0]  cnt_sum;
    logic                         have_code;
    logic [MAX_CODE_BITS-1:0]     code;
    logic [CMP_W-1:0]             code_c, nfc_c, nfc_after;
    logic                         is_clear, is_end, is_known, is_kwk, room, grow;

    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;
    assign cur_phase = in_start ? glzw_pkg::PH_SIZE : phase_reg;

    assign merged    = buf_reg | (glzw_pkg::BUF_W'(in_byte) << cnt_reg);
    assign cnt_sum   = cnt_reg + glzw_pkg::BCNT_W'(8);
    assign have_code = cnt_sum >= glzw_pkg::BCNT_W'(cw_reg);
    assign code_mask = (glzw_pkg::BUF_W'(1) << cw_reg) - glzw_pkg::BUF_W'(1);
    assign code_full = merged & code_mask;
    assign code      = code_full[MAX_CODE_BITS-1:0];

    assign code_c    = CMP_W'(code);
    assign nfc_c     = CMP_W'(nfc_reg);
    assign room      = nfc_c < CMP_W'(DICT_DEPTH);
    assign is_clear  = code_c == CMP_W'(glzw_pkg::CODE_CLEAR);
    assign is_end    = code_c == CMP_W'(glzw_pkg::CODE_END);
    assign is_known  = code_c < nfc_c;
    assign is_kwk    = (code_c == nfc_c) && !fresh_reg && room;
    assign nfc_after = room ? nfc_c + CMP_W'(1) : nfc_c;
    assign grow      = (nfc_after >= (CMP_W'(1) << cw_reg))
                       && (cw_reg < glzw_pkg::CW_W'(MAX_CODE_BITS));

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (cur_phase)
                glzw_pkg::PH_SIZE: phase_next = (in_byte == 8'(glzw_pkg::SIZE_BYTE)) ?
                                                glzw_pkg::PH_LEN : glzw_pkg::PH_IDLE;
                glzw_pkg::PH_LEN:  phase_next = (in_byte == 8'd0) ?
                                                glzw_pkg::PH_IDLE : glzw_pkg::PH_DATA;
                glzw_pkg::PH_DATA: phase_next = (rem_reg == 8'd1) ?
                                                glzw_pkg::PH_LEN : glzw_pkg::PH_DATA;
                glzw_pkg::PH_IDLE: phase_next = glzw_pkg::PH_IDLE;
                default:           phase_next = glzw_pkg::PH_IDLE;
            endcase
        end
    end

    always_comb begin
        rem_next   = rem_reg;
        stop_next  = stop_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        cw_next    = cw_reg;
        nfc_next   = nfc_reg;
        prev_next  = prev_reg;
        fresh_next = fresh_reg;
        cmd_push   = 1'b0;
        cmd        = '0;
        if (accept) begin
            unique case (cur_phase)
                glzw_pkg::PH_SIZE: begin
                    buf_next   = '0;
                    cnt_next   = '0;
                    rem_next   = '0;
                    stop_next  = 1'b0;
                    nfc_next   = NFC_W'(glzw_pkg::FIRST_FREE);
                    cw_next    = glzw_pkg::CW_W'(glzw_pkg::INIT_WIDTH);
                    prev_next  = '0;
                    fresh_next = 1'b1;
                    if (in_byte != 8'(glzw_pkg::SIZE_BYTE)) begin
                        cmd_push      = 1'b1;
                        cmd.is_status = 1'b1;
                        cmd.status    = glzw_pkg::ST_BAD_SIZE;
                    end
                end
                glzw_pkg::PH_LEN: begin
                    if (in_byte == 8'd0) begin
                        if (!stop_reg) begin
                            stop_next     = 1'b1;
                            cmd_push      = 1'b1;
                            cmd.is_status = 1'b1;
                            cmd.status    = glzw_pkg::ST_END;
                        end
                    end else begin
                        rem_next = in_byte;
                    end
                end
                glzw_pkg::PH_DATA: begin
                    rem_next = rem_reg - 8'd1;
                    if (!stop_reg) begin
                        buf_next = merged;
                        cnt_next = cnt_sum;
                        if (have_code) begin
                            buf_next = merged >> cw_reg;
                            cnt_next = cnt_sum - glzw_pkg::BCNT_W'(cw_reg);
                            priority if (is_clear) begin
                                nfc_next   = NFC_W'(glzw_pkg::FIRST_FREE);
                                cw_next    = glzw_pkg::CW_W'(glzw_pkg::INIT_WIDTH);
                                prev_next  = '0;
                                fresh_next = 1'b1;
                            end else if (is_end) begin
                                stop_next     = 1'b1;
                                cmd_push      = 1'b1;
                                cmd.is_status = 1'b1;
                                cmd.status    = glzw_pkg::ST_END;
                            end else if (is_known || is_kwk) begin
                                cmd_push       = 1'b1;
                                cmd.walk_code  = is_kwk ? glzw_pkg::FIELD_W'(prev_reg)
                                                        : glzw_pkg::FIELD_W'(code);
                                cmd.kwk        = is_kwk;
                                cmd.add        = room && !fresh_reg;
                                cmd.add_addr   = glzw_pkg::FIELD_W'(nfc_reg[AW-1:0]);
                                cmd.add_prefix = glzw_pkg::FIELD_W'(prev_reg);
                                nfc_next       = NFC_W'(nfc_after);
                                fresh_next     = 1'b0;
                                prev_next      = code;
                                if (grow) begin
                                    cw_next = cw_reg + glzw_pkg::CW_W'(1);
                                end
                            end else begin
                                stop_next     = 1'b1;
                                cmd_push      = 1'b1;
                                cmd.is_status = 1'b1;
                                cmd.status    = glzw_pkg::ST_INVALID;
                            end
                        end
                    end
                end
                glzw_pkg::PH_IDLE: begin
                    cmd_push = 1'b0;
                end
                default: begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg <= glzw_pkg::PH_SIZE;
            rem_reg   <= '0;
            stop_reg  <= 1'b0;
            buf_reg   <= '0;
            cnt_reg   <= '0;
            cw_reg    <= glzw_pkg::CW_W'(glzw_pkg::INIT_WIDTH);
            nfc_reg   <= NFC_W'(glzw_pkg::FIRST_FREE);
            prev_reg  <= '0;
            fresh_reg <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            stop_reg  <= stop_next;
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            cw_reg    <= cw_next;
            nfc_reg   <= nfc_next;
            prev_reg  <= prev_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

// ===== rtl/core/glzw_cmdq.sv =====
module glzw_cmdq (
    input  logic              clk,
    input  logic              rstn,
    input  logic              push,
    input  glzw_pkg::cmd_t    push_data,
    input  logic              pop,
    output glzw_pkg::cmd_t    head,
    output logic              full,
    output logic              empty
);

    glzw_pkg::cmd_t slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = slot_reg[rd_reg];

    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/glzw_back.sv =====
module glzw_back #(
    parameter int DICT_DEPTH = 4096
) (
    input  logic                            clk,
    input  logic                            rstn,
    input  logic                            q_empty,
    input  glzw_pkg::cmd_t                  q_head,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [glzw_pkg::GRP_W-1:0]      out_pixels,
    output logic [glzw_pkg::PCOUNT_W-1:0]   out_count,
    output logic                            out_last,
    output logic [1:0]                      out_status
);

    localparam int AW  = $clog2(DICT_DEPTH);
    localparam int LW  = AW + 1;
    localparam int GPW = glzw_pkg::PCOUNT_W;

    glzw_pkg::back_state_t state_reg, state_next;
    glzw_pkg::cmd_t        cmd_reg, cmd_next;

    // dictionary: string length, prefix code, last byte
    logic [LW-1:0] len_mem [DICT_DEPTH];
    logic [AW-1:0] pre_mem [DICT_DEPTH];
    logic [7:0]    suf_mem [DICT_DEPTH];
    logic [7:0]    stk_mem [DICT_DEPTH];

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] len_q;
    logic [AW-1:0] pre_q;
    logic [7:0]    suf_q, root_val_q;
    logic          root_q;
    logic [LW-1:0] e_len, e_len_c;
    logic [AW-1:0] e_pre;
    logic [7:0]    e_suf;

    logic          dict_we;
    logic [AW-1:0] dict_waddr;
    logic [LW-1:0] dict_wlen;

    logic          stk_we, stk_re;
    logic [AW-1:0] stk_waddr, stk_raddr;
    logic [7:0]    stk_wdata, stk_q;

    logic [LW-1:0] pos_reg, pos_next, pos_eff;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] last_len_reg, last_len_next;
    logic [7:0]    first_reg, first_next;
    logic [LW-1:0] issue_reg, issue_next;
    logic [LW-1:0] cap_reg, cap_next;
    logic [LW-1:0] base_reg, base_next;
    logic [GPW-1:0] grp_n_reg, grp_n_next;
    logic [glzw_pkg::GRP_W-1:0] grp_reg, grp_next;
    logic          pend_reg, pend_next;
    logic          can_issue, grp_done, out_free, last_grp;

    logic                          ovalid_reg, ovalid_next;
    logic [glzw_pkg::GRP_W-1:0]    opix_reg, opix_next;
    logic [GPW-1:0]                ocnt_reg, ocnt_next;
    logic                          olast_reg, olast_next;
    logic [1:0]                    ost_reg, ost_next;

    assign e_len   = root_q ? LW'(1) : len_q;
    assign e_len_c = (e_len == '0) ? LW'(1) : e_len;
    assign e_pre   = root_q ? '0 : pre_q;
    assign e_suf   = root_q ? root_val_q : suf_q;
    assign pos_eff = (state_reg == glzw_pkg::BK_LEN) ? e_len_c : pos_reg;

    assign can_issue = (issue_reg < len_reg)
                       && ((issue_reg - base_reg) < LW'(glzw_pkg::PIX_PER_GRP));
    assign grp_done  = pend_reg && ((grp_n_reg + GPW'(1) == GPW'(glzw_pkg::PIX_PER_GRP))
                                    || (cap_reg + LW'(1) == len_reg));
    assign out_free  = !ovalid_reg || out_ready;
    assign last_grp  = cap_reg == len_reg;

    assign out_valid  = ovalid_reg;
    assign out_pixels = opix_reg;
    assign out_count  = ocnt_reg;
    assign out_last   = olast_reg;
    assign out_status = ost_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            glzw_pkg::BK_IDLE: if (!q_empty) begin
                state_next = q_head.is_status ? glzw_pkg::BK_STAT : glzw_pkg::BK_LOOK;
            end
            glzw_pkg::BK_LOOK: state_next = glzw_pkg::BK_LEN;
            glzw_pkg::BK_LEN,
            glzw_pkg::BK_WALK: state_next = (pos_eff == LW'(1)) ?
                                            glzw_pkg::BK_FIN : glzw_pkg::BK_WALK;
            glzw_pkg::BK_FIN:  state_next = glzw_pkg::BK_FILL;
            glzw_pkg::BK_FILL: if (grp_done) begin
                state_next = glzw_pkg::BK_EMIT;
            end
            glzw_pkg::BK_EMIT: if (out_free) begin
                state_next = last_grp ? glzw_pkg::BK_IDLE : glzw_pkg::BK_FILL;
            end
            glzw_pkg::BK_STAT: if (out_free) begin
                state_next = glzw_pkg::BK_IDLE;
            end
            default: state_next = glzw_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop         = 1'b0;
        cmd_next      = cmd_reg;
        rd_en         = 1'b0;
        rd_addr       = cmd_reg.walk_code[AW-1:0];
        dict_we       = 1'b0;
        dict_waddr    = cmd_reg.add_addr[AW-1:0];
        dict_wlen     = last_len_reg + LW'(1);
        stk_we        = 1'b0;
        stk_waddr     = pos_eff[AW-1:0] - AW'(1);
        stk_wdata     = e_suf;
        stk_re        = 1'b0;
        stk_raddr     = issue_reg[AW-1:0];
        pos_next      = pos_reg;
        len_next      = len_reg;
        last_len_next = last_len_reg;
        first_next    = first_reg;
        issue_next    = issue_reg;
        cap_next      = cap_reg;
        base_next     = base_reg;
        grp_n_next    = grp_n_reg;
        grp_next      = grp_reg;
        pend_next     = 1'b0;
        ovalid_next   = ovalid_reg && !out_ready;
        opix_next     = opix_reg;
        ocnt_next     = ocnt_reg;
        olast_next    = olast_reg;
        ost_next      = ost_reg;
        unique case (state_reg)
            glzw_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                end
            end
            glzw_pkg::BK_LOOK: begin
                rd_en = 1'b1;
            end
            glzw_pkg::BK_LEN,
            glzw_pkg::BK_WALK: begin
                // write the string back to front, one dictionary step a cycle
                if (state_reg == glzw_pkg::BK_LEN) begin
                    len_next = e_len_c;
                end
                stk_we = 1'b1;
                if (pos_eff == LW'(1)) begin
                    first_next = e_suf;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = e_pre;
                    pos_next = pos_eff - LW'(1);
                end
            end
            glzw_pkg::BK_FIN: begin
                if (cmd_reg.kwk && (len_reg < LW'(DICT_DEPTH))) begin
                    stk_we    = 1'b1;
                    stk_waddr = len_reg[AW-1:0];
                    stk_wdata = first_reg;
                    len_next  = len_reg + LW'(1);
                end
                if (cmd_reg.add) begin
                    dict_we = 1'b1;
                end
                last_len_next = len_next;
                issue_next    = '0;
                cap_next      = '0;
                base_next     = '0;
                grp_n_next    = '0;
                grp_next      = '0;
            end
            glzw_pkg::BK_FILL: begin
                if (pend_reg) begin
                    grp_next[grp_n_reg[GPW-2:0]*8 +: 8] = stk_q;
                    grp_n_next = grp_n_reg + GPW'(1);
                    cap_next   = cap_reg + LW'(1);
                end
                if (can_issue) begin
                    stk_re     = 1'b1;
                    issue_next = issue_reg + LW'(1);
                    pend_next  = 1'b1;
                end
            end
            glzw_pkg::BK_EMIT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    opix_next   = grp_reg;
                    ocnt_next   = grp_n_reg;
                    olast_next  = last_grp;
                    ost_next    = glzw_pkg::ST_PIXELS;
                    base_next   = cap_reg;
                    grp_n_next  = '0;
                    grp_next    = '0;
                end
            end
            glzw_pkg::BK_STAT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    opix_next   = '0;
                    ocnt_next   = '0;
                    olast_next  = 1'b1;
                    ost_next    = cmd_reg.status;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (dict_we) begin
            len_mem[dict_waddr] <= dict_wlen;
            pre_mem[dict_waddr] <= cmd_reg.add_prefix[AW-1:0];
            suf_mem[dict_waddr] <= first_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            len_q      <= len_mem[rd_addr];
            pre_q      <= pre_mem[rd_addr];
            suf_q      <= suf_mem[rd_addr];
            root_q     <= rd_addr < AW'(glzw_pkg::ROOT_COUNT);
            root_val_q <= rd_addr[7:0];
        end
    end

    always_ff @(posedge clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (stk_re) begin
            stk_q <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk) begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        first_reg    <= first_next;
        issue_reg    <= issue_next;
        cap_reg      <= cap_next;
        base_reg     <= base_next;
        grp_n_reg    <= grp_n_next;
        grp_reg      <= grp_next;
        opix_reg     <= opix_next;
        ocnt_reg     <= ocnt_next;
        olast_reg    <= olast_next;
        ost_reg      <= ost_next;
        last_len_reg <= last_len_next;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg  <= glzw_pkg::BK_IDLE;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef SYNTH
    a_walk_pos: assert property (@(posedge clk) disable iff (!rstn)
        state_reg == glzw_pkg::BK_WALK |-> pos_reg != '0)
        else $error("chain walk with empty position");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rstn)
        state_reg == glzw_pkg::BK_FILL |-> issue_reg <= len_reg && cap_reg <= issue_reg)
        else $error("stack read beyond string");

    a_pix_count: assert property (@(posedge clk) disable iff (!rstn)
        ovalid_reg && ost_reg == glzw_pkg::ST_PIXELS |->
            ocnt_reg != '0 && ocnt_reg <= GPW'(glzw_pkg::PIX_PER_GRP))
        else $error("pixel group with bad count");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rstn)
        q_pop |-> state_reg == glzw_pkg::BK_IDLE && !q_empty)
        else $error("command taken while busy");
`endif

endmodule

// ===== rtl/core/gif_lzw_decoder.sv =====
// GIF image-data LZW decoder, 8-bit roots, codes of 9 to MAX_CODE_BITS bits.
// Input stream: one byte of the image-data section per transfer in
// s_axis_tdata; s_axis_tuser marks the code-size byte of a new section and
// restarts the parser. Output stream: groups of up to 64 pixel bytes in
// m_axis_tdata with their count; m_axis_tuser gives the status (pixels, end of
// image, invalid code, unsupported code size); m_axis_tlast is set on the last
// transfer caused by an input byte.
// The parser takes one byte per cycle and posts at most one command per byte
// into a two-entry queue; it stalls only when that queue is full.
// The expander handles one command at a time: for a code it does one dictionary
// read per chain step, then one stack read per byte, and sends the bytes in
// groups of up to 64; a status is passed straight to the output register.
// The dictionary needs no clearing: root entries are formed on the fly and other
// entries are read only after being written.
// Reset clears the parser, the queue and the output register. A stalled
// receiver holds the output register; the expander then waits and the queue
// fills, after which s_axis_tready drops.
module gif_lzw_decoder #(
    parameter int DICT_DEPTH    = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // data_byte
    input  logic [0:0]                    s_axis_tuser,  // start_req
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixels_0 .. pixels_63, pixel_count, one zero pad bit
    output logic [glzw_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic [1:0]                    m_axis_tuser   // status
);

    glzw_pkg::cmd_t cmd, q_head;
    logic cmd_push, q_pop, q_full, q_empty;
    logic [glzw_pkg::GRP_W-1:0]    pixels;
    logic [glzw_pkg::PCOUNT_W-1:0] pcount;

    glzw_front #(
        .DICT_DEPTH    (DICT_DEPTH),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .clk      (aclk),
        .rstn     (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_start (s_axis_tuser[0]),
        .q_full   (q_full),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    glzw_cmdq u_cmdq (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    glzw_back #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_back (
        .clk        (aclk),
        .rstn       (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_pixels (pixels),
        .out_count  (pcount),
        .out_last   (m_axis_tlast),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, pcount, pixels};

endmodule

// ===== tb/sv/gif_lzw_decoder_checker.sv =====
`timescale 1ns / 100ps

module gif_lzw_decoder_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,
    input  logic [0:0]                    s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [glzw_pkg::TDATA_W-1:0]  m_axis_tdata,
    input  logic                          m_axis_tlast,
    input  logic [1:0]                    m_axis_tuser,
    output int                            fail_count,
    output int                            pending_groups
);

    typedef struct {
        logic [glzw_pkg::GRP_W-1:0]    pixels;
        logic [glzw_pkg::PCOUNT_W-1:0] count;
        logic                          last;
        logic [1:0]                    status;
    } group_t;

    group_t expected_groups[$];

    logic [11:0] dict_prefix[4096];
    logic [7:0]  dict_suffix[4096];
    logic [11:0] dict_len[4096];
    logic [7:0]  string_buf[4096];
    int          prev_code;
    int          free_code;
    int          width;
    logic [19:0] bits;
    int          nbits;
    int          remaining;
    glzw_pkg::phase_t phase;
    bit          fresh;
    bit          halted;

    assign pending_groups = expected_groups.size();

    function automatic void reset_dictionary();
        for (int i = 0; i < glzw_pkg::ROOT_COUNT; i++) begin
            dict_prefix[i] = '0;
            dict_suffix[i] = i[7:0];
            dict_len[i]    = 12'd1;
        end
        free_code = glzw_pkg::FIRST_FREE;
        width     = glzw_pkg::INIT_WIDTH;
        prev_code = 0;
        fresh     = 1'b1;
    endfunction

    function automatic void push_status(logic [1:0] st);
        group_t g;
        g.pixels = '0;
        g.count  = '0;
        g.last   = 1'b1;
        g.status = st;
        expected_groups.push_back(g);
    endfunction

    function automatic int unroll_string(int code);
        int len;
        int c;
        c   = code % 4096;
        len = dict_len[c];
        if (len < 1) len = 1;
        for (int pos = len; pos > 0; pos--) begin
            string_buf[pos-1] = dict_suffix[c];
            c = dict_prefix[c];
        end
        return len;
    endfunction

    function automatic void push_pixels(int len);
        group_t g;
        int n;
        int i;
        i = 0;
        while (i < len) begin
            g.pixels = '0;
            g.status = glzw_pkg::ST_PIXELS;
            g.last   = 1'b0;
            n = 0;
            while (n < glzw_pkg::PIX_PER_GRP && i < len) begin
                g.pixels[8*n +: 8] = string_buf[i];
                n++;
                i++;
            end
            g.count = glzw_pkg::PCOUNT_W'(n);
            if (i >= len) g.last = 1'b1;
            expected_groups.push_back(g);
        end
    endfunction

    function automatic void decode_code(int code);
        int len;
        int p;
        if (code == glzw_pkg::CODE_CLEAR) begin
            reset_dictionary();
            return;
        end
        if (code == glzw_pkg::CODE_END) begin
            halted = 1'b1;
            push_status(glzw_pkg::ST_END);
            return;
        end
        if (code < free_code && code < 4096) begin
            len = unroll_string(code);
        end else if (code == free_code && !fresh && free_code < 4096) begin
            len = unroll_string(prev_code);
            if (len < 4096) begin
                string_buf[len] = string_buf[0];
                len++;
            end
        end else begin
            halted = 1'b1;
            push_status(glzw_pkg::ST_INVALID);
            return;
        end
        if (free_code < 4096) begin
            if (!fresh) begin
                p = prev_code % 4096;
                dict_prefix[free_code] = p[11:0];
                dict_suffix[free_code] = string_buf[0];
                dict_len[free_code]    = dict_len[p] + 12'd1;
            end
            free_code++;
        end
        fresh     = 1'b0;
        prev_code = code;
        if (free_code > (1 << width) - 1 && width < 12) width++;
        push_pixels(len);
    endfunction

    function automatic void take_byte(logic [7:0] b, logic start);
        int code;
        if (start) phase = glzw_pkg::PH_SIZE;
        case (phase)
            glzw_pkg::PH_SIZE: begin
                bits = '0;
                nbits = 0;
                remaining = 0;
                halted = 1'b0;
                reset_dictionary();
                if (b != glzw_pkg::SIZE_BYTE) begin
                    phase = glzw_pkg::PH_IDLE;
                    push_status(glzw_pkg::ST_BAD_SIZE);
                end else begin
                    phase = glzw_pkg::PH_LEN;
                end
            end
            glzw_pkg::PH_LEN: begin
                if (b == 0) begin
                    phase = glzw_pkg::PH_IDLE;
                    if (!halted) begin
                        halted = 1'b1;
                        push_status(glzw_pkg::ST_END);
                    end
                end else begin
                    remaining = b;
                    phase = glzw_pkg::PH_DATA;
                end
            end
            glzw_pkg::PH_DATA: begin
                remaining = (remaining - 1) & 8'hff;
                if (remaining == 0) phase = glzw_pkg::PH_LEN;
                if (!halted) begin
                    bits = bits | (20'(b) << nbits);
                    nbits += 8;
                    if (nbits >= width) begin
                        code = bits & ((1 << width) - 1);
                        bits = bits >> width;
                        nbits -= width;
                        decode_code(code);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        group_t want;
        if (!aresetn) begin
            expected_groups.delete();
            fail_count <= 0;
            phase  = glzw_pkg::PH_SIZE;
            halted = 1'b0;
            bits   = '0;
            nbits  = 0;
            remaining = 0;
            reset_dictionary();
        end else begin
            if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_groups.size() == 0) begin
                    $display("%0t: unexpected transfer, status %0d count %0d", $realtime,
                             m_axis_tuser,
                             m_axis_tdata[glzw_pkg::GRP_W +: glzw_pkg::PCOUNT_W]);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_groups.pop_front();
                    if (m_axis_tdata[glzw_pkg::GRP_W-1:0] !== want.pixels ||
                        m_axis_tdata[glzw_pkg::GRP_W +: glzw_pkg::PCOUNT_W] !== want.count ||
                        m_axis_tdata[glzw_pkg::TDATA_W-1] !== 1'b0 ||
                        m_axis_tlast !== want.last || m_axis_tuser !== want.status) begin
                        $display("%0t: expected st %0d cnt %0d last %0b pix %h",
                                 $realtime, want.status, want.count, want.last, want.pixels);
                        $display("%0t: actual   st %0d cnt %0d last %0b pix %h",
                                 $realtime, m_axis_tuser,
                                 m_axis_tdata[glzw_pkg::GRP_W +: glzw_pkg::PCOUNT_W],
                                 m_axis_tlast, m_axis_tdata[glzw_pkg::GRP_W-1:0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/gif_lzw_decoder_tb.sv =====
`timescale 1ns / 100ps

module gif_lzw_decoder_tb;

    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 330;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;
    logic [0:0]                    s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [glzw_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                          m_axis_tlast;
    logic [1:0]                    m_axis_tuser;
    int                            fail_count;
    int                            pending_groups;
    int                            quiet_cycles;
    int                            bytes_sent;
    bit                            calm;

    // Code stream being packed for the current section
    logic [7:0] section_bytes[$];
    logic [31:0] pack_bits;
    int          pack_count;
    int          pack_width;
    int          pack_free;

    gif_lzw_decoder dut (.*);

    gif_lzw_decoder_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver stalls in short bursts
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold tvalid after a transfer; the next call replaces the data or idles
    task automatic send_byte(input logic [7:0] b, input logic start);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Pack one code LSB-first; mirror the decoder's width growth
    task automatic put_code(input int code);
        pack_bits  = pack_bits | (32'(code) << pack_count);
        pack_count += pack_width;
        while (pack_count >= 8) begin
            section_bytes.push_back(pack_bits[7:0]);
            pack_bits = pack_bits >> 8;
            pack_count -= 8;
        end
        if (code == glzw_pkg::CODE_CLEAR) begin
            pack_free  = glzw_pkg::FIRST_FREE;
            pack_width = glzw_pkg::INIT_WIDTH;
        end else if (code != glzw_pkg::CODE_END && pack_free < 4096) begin
            pack_free++;
            if (pack_free > (1 << pack_width) - 1 && pack_width < 12) pack_width++;
        end
    endtask

    task automatic begin_section();
        section_bytes.delete();
        pack_bits  = 0;
        pack_count = 0;
        pack_width = glzw_pkg::INIT_WIDTH;
        pack_free  = glzw_pkg::FIRST_FREE;
    endtask

    // Size byte, sub-blocks of given maximum length, optional terminator
    task automatic send_section(input int max_block, input bit terminate);
        int n;
        if (pack_count > 0) section_bytes.push_back(pack_bits[7:0]);
        send_byte(8'd8, 1'b1);
        while (section_bytes.size() > 0) begin
            n = $urandom_range(1, max_block);
            if (n > section_bytes.size()) n = section_bytes.size();
            send_byte(n[7:0], 1'b0);
            repeat (n) send_byte(section_bytes.pop_front(), 1'b0);
        end
        if (terminate) send_byte(8'd0, 1'b0);
    endtask

    // Codes mostly valid: roots, existing entries, KwKwK, occasional clear
    task automatic random_section(input int ncodes, input int max_block);
        int r;
        begin_section();
        put_code(glzw_pkg::CODE_CLEAR);
        put_code($urandom_range(0, 255));
        for (int i = 0; i < ncodes; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      put_code($urandom_range(0, 255));
            else if (r < 80) put_code($urandom_range(258, pack_free - 1 > 258 ?
                                                     pack_free - 1 : 258));
            else if (r < 92) put_code(pack_free);
            else if (r < 96) begin
                put_code(glzw_pkg::CODE_CLEAR);
                put_code($urandom_range(0, 255));
            end else if (r < 98) put_code(pack_free + $urandom_range(1, 5));
            else put_code(glzw_pkg::CODE_END);
        end
        if ($urandom_range(0, 1)) put_code(glzw_pkg::CODE_END);
        send_section(max_block, 1'b1);
    endtask

    initial begin
        int junk;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        quiet_cycles  = 0;
        bytes_sent    = 0;
        calm          = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // unsupported code sizes and an idle byte that must be ignored
        send_byte(8'd0, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'd7, 1'b1);
        send_byte(8'd255, 1'b1);
        // empty section: terminator alone ends the image
        send_byte(8'd8, 1'b1);
        send_byte(8'd0, 1'b0);
        // roots 0 and 255, KwKwK, clear, root 170, end code, then ignored codes
        begin_section();
        put_code(0);
        put_code(255);
        put_code(pack_free);
        put_code(glzw_pkg::CODE_CLEAR);
        put_code(170);
        put_code(glzw_pkg::CODE_END);
        put_code(85);
        send_section(255, 1'b1);
        // invalid code right after clear
        begin_section();
        put_code(glzw_pkg::CODE_CLEAR);
        put_code(300);
        send_section(4, 1'b1);
        // restart in the middle of a section
        begin_section();
        put_code(65);
        send_section(2, 1'b0);

        // long run of repeats grows strings beyond 64 bytes
        begin_section();
        put_code(glzw_pkg::CODE_CLEAR);
        put_code(7);
        for (int i = 0; i < 70; i++) put_code(pack_free);
        put_code(glzw_pkg::CODE_END);
        send_section(255, 1'b1);

        while (bytes_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                junk = $urandom_range(0, 7);
                repeat (junk) send_byte(8'($urandom_range(0, 255)),
                                        $urandom_range(0, 3) == 0);
            end else begin
                random_section($urandom_range(5, 60), $urandom_range(1, 255));
            end
            if (bytes_sent > RANDOM_ITEMS - 40) calm = 1'b1;
        end

        // repeats mixed with roots, sent without pauses
        begin_section();
        put_code(glzw_pkg::CODE_CLEAR);
        put_code(3);
        for (int i = 0; i < 60; i++)
            put_code(i % 3 == 0 ? pack_free : $urandom_range(0, 255));
        put_code(pack_free);
        send_section(255, 1'b1);
        s_axis_tvalid <= 1'b0;

        while (pending_groups != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
